@@ src/wlfb_pkg.sv @@
`default_nettype none

package wlfb_pkg;

   // Default build parameters
   localparam int PIXEL_DEPTH_DEF   = 65536;
   localparam int WINDOW_RADIUS_DEF = 8;

   // Fixed field widths
   localparam int PIXEL_BITS    = 16;
   localparam int KEEP_SMALLEST = 5;
   localparam int REG_W         = 13;
   localparam int CSR_IDX_W     = 2;
   localparam int ADDR_IN_W     = 16;
   localparam int COORD_W       = 24;
   localparam int FRAC_BITS     = 8;
   localparam int WHOLE_W       = 16;
   localparam int FIFTHS_W      = 3;

   // Register reset values
   localparam int HEIGHT_RESET = 256;
   localparam int WIDTH_RESET  = 256;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;

   // Operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Sum of kept pixels and divide by KEEP_SMALLEST via reciprocal
   localparam int SUM_W     = PIXEL_BITS + $clog2(KEEP_SMALLEST);
   localparam int DIV_SHIFT = 22;
   localparam int RCP_W     = 20;
   localparam int RECIP     = ((1 << DIV_SHIFT) + KEEP_SMALLEST - 1) / KEEP_SMALLEST;
   localparam int PROD_W    = SUM_W + RCP_W;

   // Signed window bound and address-limit widths
   localparam int CRD_W = WHOLE_W + 2;
   localparam int LIM_W = 28;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_LIMIT,
      ST_SWEEP,
      ST_DRAIN,
      ST_SUM,
      ST_DIV,
      ST_REM,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ src/wlfb_ram.sv @@
`default_nettype none

module wlfb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/window_lowest_five_background_unit.sv @@
`default_nettype none

// Local background estimator for a column-major bead image.
// Request channel (req_*, valid/ready): op selects a pixel write or a bead
// query. A write stores req_pixel_value at req_pixel_addr and gives no
// response word. A query takes the bead position in 16.8 fixed point,
// scans the (2*WINDOW_RADIUS+1)^2 window around it and returns the mean of
// the five smallest pixels as a whole part plus fifths.
// Response channel (rsp_*, valid/ready): one word per query.
// A query holds the block until its response word is loaded. The window
// scan is paced by the single read port of the pixel memory, which returns
// one window pixel per cycle. A window that leaves the image is flagged
// with zero values and no scan. One multiplier is shared by the address
// setup and the divide by five.
// req_ready is high whenever the sequencer is idle; a finished response sits
// in the output register, so a held rsp_ready only stalls the block once a
// second query result is ready. Writes too are accepted only while idle.
// Reset (synchronous) clears the sequencer and output valid and sets both
// image dimensions to 256; the pixel memory is not cleared. The user must
// make config writes (csr_*) while no query is in flight; nothing checks it.
module window_lowest_five_background_unit #(
   parameter int PIXEL_DEPTH   = wlfb_pkg::PIXEL_DEPTH_DEF,
   parameter int WINDOW_RADIUS = wlfb_pkg::WINDOW_RADIUS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_op,
   input  wire logic [wlfb_pkg::ADDR_IN_W-1:0]       req_pixel_addr,
   input  wire logic [15:0]                          req_pixel_value,
   input  wire logic [wlfb_pkg::COORD_W-1:0]         req_bead_x,
   input  wire logic [wlfb_pkg::COORD_W-1:0]         req_bead_y,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic      [wlfb_pkg::WHOLE_W-1:0]         rsp_background_whole,
   output logic      [wlfb_pkg::FIFTHS_W-1:0]        rsp_background_fifths,
   output logic                                      rsp_out_of_range,
   // configuration port
   input  wire logic                                 csr_we,
   input  wire logic [wlfb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [wlfb_pkg::REG_W-1:0]           csr_wdata
);

   localparam int ADDR_W   = $clog2(PIXEL_DEPTH);
   localparam int SPAN     = 2 * WINDOW_RADIUS + 1;
   localparam int CNT_W    = $clog2(SPAN);
   localparam int WADDR_W  = 25;
   localparam int PB       = wlfb_pkg::PIXEL_BITS;
   localparam int KEEP     = wlfb_pkg::KEEP_SMALLEST;
   localparam int CRD_W    = wlfb_pkg::CRD_W;
   localparam int LIM_W    = wlfb_pkg::LIM_W;
   localparam int SUM_W    = wlfb_pkg::SUM_W;
   localparam int RCP_W    = wlfb_pkg::RCP_W;
   localparam int PROD_W   = wlfb_pkg::PROD_W;
   localparam int REG_W    = wlfb_pkg::REG_W;
   localparam int WHOLE_W  = wlfb_pkg::WHOLE_W;
   localparam int FIFTHS_W = wlfb_pkg::FIFTHS_W;
   localparam int FRAC     = wlfb_pkg::FRAC_BITS;

   wlfb_pkg::state_type state_ff, state_in;

   logic [REG_W-1:0]   height_ff, height_in;
   logic [REG_W-1:0]   width_ff, width_in;
   logic [CRD_W-1:0]   c0_ff, c0_in, c1_ff, c1_in, r0_ff, r0_in, r1_ff, r1_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [ADDR_W-1:0]  col_addr_ff, col_addr_in;
   logic [CNT_W-1:0]   row_cnt_ff, row_cnt_in, col_cnt_ff, col_cnt_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [PB-1:0]      kept_ff [KEEP];
   logic [PB-1:0]      kept_in [KEEP];
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [WHOLE_W-1:0] whole_ff, whole_in;
   logic [FIFTHS_W-1:0] fifths_ff, fifths_in;
   logic               oor_ff, oor_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WHOLE_W-1:0] rsp_whole_ff, rsp_whole_in;
   logic [FIFTHS_W-1:0] rsp_fifths_ff, rsp_fifths_in;
   logic               rsp_oor_ff, rsp_oor_in;

   // control from the sequencer
   logic               ready_c;
   logic               slot_free;
   logic               rsp_load;
   logic               sweep_c;
   logic [SUM_W-1:0]   mul_a;
   logic [RCP_W-1:0]   mul_b;

   // datapath helpers
   logic               accept;
   logic               query_go;
   logic               out_bad;
   logic               row_last, col_last;
   logic [LIM_W-1:0]   lim_addr;
   logic [CRD_W-1:0]   cx, cy;
   logic [ADDR_W-1:0]  rd_addr;
   logic [PB-1:0]      rd_data;
   logic               wr_en;
   logic [WADDR_W-1:0] wr_addr_wide;
   logic [KEEP-1:0]    lt;
   logic [WHOLE_W-1:0] quot;
   logic [SUM_W-1:0]   rem_full;

   assign accept   = req_valid && ready_c;
   assign query_go = accept && (req_op == wlfb_pkg::OP_QUERY);
   assign row_last = (row_cnt_ff == CNT_W'(SPAN - 1));
   assign col_last = (col_cnt_ff == CNT_W'(SPAN - 1));

   // window bound check against image size and memory depth
   assign lim_addr = prod_ff[LIM_W-1:0] + LIM_W'(r1_ff);
   assign out_bad  = c0_ff[CRD_W-1] || r0_ff[CRD_W-1] ||
                     (c1_ff >= CRD_W'(width_ff)) || (r1_ff >= CRD_W'(height_ff)) ||
                     (lim_addr >= LIM_W'(PIXEL_DEPTH));

   // window centre: integer part, one less when the fraction is zero
   assign cx = CRD_W'(req_bead_x[wlfb_pkg::COORD_W-1:FRAC])
             - CRD_W'(req_bead_x[FRAC-1:0] == '0);
   assign cy = CRD_W'(req_bead_y[wlfb_pkg::COORD_W-1:FRAC])
             - CRD_W'(req_bead_y[FRAC-1:0] == '0);

   // pixel memory
   assign wr_addr_wide = WADDR_W'(req_pixel_addr);
   assign wr_en        = accept && (req_op == wlfb_pkg::OP_WRITE) &&
                         (wr_addr_wide < WADDR_W'(PIXEL_DEPTH));
   assign rd_addr      = ADDR_W'(col_addr_ff + ADDR_W'(row_cnt_ff));

   wlfb_ram #(
      .WIDTH (PB),
      .DEPTH (PIXEL_DEPTH)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_wide[ADDR_W-1:0]),
      .wr_data (req_pixel_value[PB-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wlfb_pkg::ST_IDLE:   if (query_go) state_in = wlfb_pkg::ST_MUL_LO;
         wlfb_pkg::ST_MUL_LO: state_in = wlfb_pkg::ST_MUL_HI;
         wlfb_pkg::ST_MUL_HI: state_in = wlfb_pkg::ST_LIMIT;
         wlfb_pkg::ST_LIMIT: begin
            state_in = out_bad ? wlfb_pkg::ST_DONE : wlfb_pkg::ST_SWEEP;
         end
         wlfb_pkg::ST_SWEEP:  if (row_last && col_last) state_in = wlfb_pkg::ST_DRAIN;
         wlfb_pkg::ST_DRAIN:  state_in = wlfb_pkg::ST_SUM;
         wlfb_pkg::ST_SUM:    state_in = wlfb_pkg::ST_DIV;
         wlfb_pkg::ST_DIV:    state_in = wlfb_pkg::ST_REM;
         wlfb_pkg::ST_REM:    state_in = wlfb_pkg::ST_DONE;
         wlfb_pkg::ST_DONE:   if (slot_free) state_in = wlfb_pkg::ST_IDLE;
         default:             state_in = wlfb_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs, including the shared multiplier operand select
   always_comb begin
      slot_free = !rsp_valid_ff || rsp_ready;
      ready_c   = 1'b0;
      rsp_load  = 1'b0;
      sweep_c   = 1'b0;
      mul_a     = sum_ff;
      mul_b     = RCP_W'(wlfb_pkg::RECIP);
      unique case (state_ff)
         wlfb_pkg::ST_IDLE:   ready_c = 1'b1;
         wlfb_pkg::ST_MUL_LO: begin
            mul_a = SUM_W'(c0_ff[REG_W-1:0]);
            mul_b = RCP_W'(height_ff);
         end
         wlfb_pkg::ST_MUL_HI: begin
            mul_a = SUM_W'(c1_ff[REG_W-1:0]);
            mul_b = RCP_W'(height_ff);
         end
         wlfb_pkg::ST_SWEEP:  sweep_c = 1'b1;
         wlfb_pkg::ST_DONE:   rsp_load = slot_free;
         default: ;
      endcase
   end

   // divide by five: quotient from the reciprocal product, remainder by subtract
   assign quot     = prod_ff[wlfb_pkg::DIV_SHIFT +: WHOLE_W];
   assign rem_full = sum_ff - SUM_W'(SUM_W'(quot) * SUM_W'(KEEP));

   // insertion into the ascending list of smallest pixels
   always_comb begin
      for (int i = 0; i < KEEP; i++) begin
         lt[i] = rd_data < kept_ff[i];
      end
   end

   // datapath next values
   always_comb begin
      height_in     = height_ff;
      width_in      = width_ff;
      c0_in         = c0_ff;
      c1_in         = c1_ff;
      r0_in         = r0_ff;
      r1_in         = r1_ff;
      prod_in       = PROD_W'(mul_a) * PROD_W'(mul_b);
      col_addr_in   = col_addr_ff;
      row_cnt_in    = row_cnt_ff;
      col_cnt_in    = col_cnt_ff;
      rd_valid_in   = sweep_c;
      kept_in       = kept_ff;
      sum_in        = sum_ff;
      whole_in      = whole_ff;
      fifths_in     = fifths_ff;
      oor_in        = oor_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_whole_in  = rsp_whole_ff;
      rsp_fifths_in = rsp_fifths_ff;
      rsp_oor_in    = rsp_oor_ff;

      // configuration registers
      if (csr_we) begin
         case (csr_index)
            wlfb_pkg::CSR_HEIGHT: height_in = csr_wdata;
            wlfb_pkg::CSR_WIDTH:  width_in  = csr_wdata;
            default: ;
         endcase
      end

      // window bounds latched on query accept
      if (query_go) begin
         c0_in = cx - CRD_W'(WINDOW_RADIUS);
         c1_in = cx + CRD_W'(WINDOW_RADIUS);
         r0_in = cy - CRD_W'(WINDOW_RADIUS);
         r1_in = cy + CRD_W'(WINDOW_RADIUS);
      end

      // first column start address
      if (state_ff == wlfb_pkg::ST_MUL_HI) begin
         col_addr_in = ADDR_W'(prod_ff[LIM_W-1:0] + LIM_W'(r0_ff));
      end

      // bounds verdict and scan setup
      if (state_ff == wlfb_pkg::ST_LIMIT) begin
         oor_in     = out_bad;
         whole_in   = '0;
         fifths_in  = '0;
         row_cnt_in = '0;
         col_cnt_in = '0;
         for (int i = 0; i < KEEP; i++) begin
            kept_in[i] = '1;
         end
      end

      // window scan, one address per cycle
      if (sweep_c) begin
         if (row_last) begin
            row_cnt_in  = '0;
            col_cnt_in  = col_cnt_ff + 1'b1;
            col_addr_in = ADDR_W'(col_addr_ff + ADDR_W'(height_ff));
         end else begin
            row_cnt_in = row_cnt_ff + 1'b1;
         end
      end

      // keep the smallest pixels seen so far
      if (rd_valid_ff) begin
         if (lt[0]) kept_in[0] = rd_data;
         for (int i = 1; i < KEEP; i++) begin
            if (lt[i]) kept_in[i] = lt[i-1] ? kept_ff[i-1] : rd_data;
         end
      end

      if (state_ff == wlfb_pkg::ST_SUM) begin
         sum_in = '0;
         for (int i = 0; i < KEEP; i++) begin
            sum_in = sum_in + SUM_W'(kept_ff[i]);
         end
      end

      if (state_ff == wlfb_pkg::ST_REM) begin
         whole_in  = quot;
         fifths_in = rem_full[FIFTHS_W-1:0];
      end

      // output register
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_whole_in  = whole_ff;
         rsp_fifths_in = fifths_ff;
         rsp_oor_in    = oor_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wlfb_pkg::ST_IDLE;
         height_ff    <= REG_W'(wlfb_pkg::HEIGHT_RESET);
         width_ff     <= REG_W'(wlfb_pkg::WIDTH_RESET);
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         height_ff    <= height_in;
         width_ff     <= width_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      c0_ff         <= c0_in;
      c1_ff         <= c1_in;
      r0_ff         <= r0_in;
      r1_ff         <= r1_in;
      prod_ff       <= prod_in;
      col_addr_ff   <= col_addr_in;
      row_cnt_ff    <= row_cnt_in;
      col_cnt_ff    <= col_cnt_in;
      kept_ff       <= kept_in;
      sum_ff        <= sum_in;
      whole_ff      <= whole_in;
      fifths_ff     <= fifths_in;
      oor_ff        <= oor_in;
      rsp_whole_ff  <= rsp_whole_in;
      rsp_fifths_ff <= rsp_fifths_in;
      rsp_oor_ff    <= rsp_oor_in;
   end

   assign req_ready             = ready_c;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_background_whole  = rsp_whole_ff;
   assign rsp_background_fifths = rsp_fifths_ff;
   assign rsp_out_of_range      = rsp_oor_ff;

endmodule

`default_nettype wire

@@ sim/wlfb_background_checker.sv @@
`timescale 1ns / 100ps

module wlfb_background_checker
   import wlfb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_op,
   input  logic [ADDR_IN_W-1:0]  req_pixel_addr,
   input  logic [PIXEL_BITS-1:0] req_pixel_value,
   input  logic [COORD_W-1:0]    req_bead_x,
   input  logic [COORD_W-1:0]    req_bead_y,
   // response channel
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [WHOLE_W-1:0]    rsp_background_whole,
   input  logic [FIFTHS_W-1:0]   rsp_background_fifths,
   input  logic                  rsp_out_of_range,
   // configuration port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]      csr_wdata,
   // status to the testbench top
   output int                    mismatch_count,
   output int                    backgrounds_owed
);

   localparam int RADIUS = WINDOW_RADIUS_DEF;
   localparam int DEPTH  = PIXEL_DEPTH_DEF;

   typedef struct packed {
      logic [WHOLE_W-1:0]  whole;
      logic [FIFTHS_W-1:0] fifths;
      logic                out_of_range;
   } background_word;

   // shadow copy of the pixel memory and the image geometry
   logic [PIXEL_BITS-1:0] image_store [DEPTH];
   logic [REG_W-1:0]      rows_per_column;
   logic [REG_W-1:0]      column_count;

   background_word pending_backgrounds [$];
   int             mismatches = 0;

   // window centre: integer part, one less when the fraction is zero
   function automatic longint window_centre(input logic [COORD_W-1:0] coord);
      longint whole;
      whole = coord >> FRAC_BITS;
      if (coord[FRAC_BITS-1:0] == '0)
         whole = whole - 1;
      return whole;
   endfunction

   // mean of the five smallest pixels of the window around one bead
   function automatic background_word lowest_five_mean(input logic [COORD_W-1:0] bx,
                                                       input logic [COORD_W-1:0] by);
      background_word        res;
      logic [PIXEL_BITS-1:0] kept [KEEP_SMALLEST];
      logic [PIXEL_BITS-1:0] pix;
      longint                col_lo, col_hi, row_lo, row_hi, h, w;
      int                    kept_n, pos, sum;
      res    = '0;
      h      = rows_per_column;
      w      = column_count;
      col_lo = window_centre(bx) - RADIUS;
      col_hi = window_centre(bx) + RADIUS;
      row_lo = window_centre(by) - RADIUS;
      row_hi = window_centre(by) + RADIUS;
      if (col_lo < 0 || row_lo < 0 || col_hi >= w || row_hi >= h ||
          col_hi * h + row_hi >= DEPTH) begin
         res.out_of_range = 1'b1;
         return res;
      end
      // insertion into a short sorted list
      kept_n = 0;
      for (longint c = col_lo; c <= col_hi; c++) begin
         for (longint r = row_lo; r <= row_hi; r++) begin
            pix = image_store[c * h + r];
            if (kept_n < KEEP_SMALLEST) begin
               pos    = kept_n;
               kept_n = kept_n + 1;
            end else if (pix < kept[KEEP_SMALLEST-1]) begin
               pos = KEEP_SMALLEST - 1;
            end else begin
               continue;
            end
            while (pos > 0 && kept[pos-1] > pix) begin
               kept[pos] = kept[pos-1];
               pos--;
            end
            kept[pos] = pix;
         end
      end
      sum = 0;
      for (int i = 0; i < kept_n; i++)
         sum += kept[i];
      res.whole  = WHOLE_W'(sum / KEEP_SMALLEST);
      res.fifths = FIFTHS_W'(sum % KEEP_SMALLEST);
      return res;
   endfunction

   always @(posedge clock) begin
      background_word got;
      background_word want;
      if (reset) begin
         rows_per_column = REG_W'(HEIGHT_RESET);
         column_count    = REG_W'(WIDTH_RESET);
         pending_backgrounds.delete();
      end else begin
         // result side: compare against the oldest owed word
         if (rsp_valid && rsp_ready) begin
            got = {rsp_background_whole, rsp_background_fifths, rsp_out_of_range};
            if (pending_backgrounds.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: background word with none owed: whole %0d fifths %0d oor %0b",
                           $time, got.whole, got.fifths, got.out_of_range);
            end else begin
               want = pending_backgrounds.pop_front();
               if (got.whole !== want.whole || got.fifths !== want.fifths ||
                   got.out_of_range !== want.out_of_range) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: background mismatch (exp/act) whole %0d/%0d %s %0d/%0d %s %0b/%0b",
                              $time, want.whole, got.whole, "fifths", want.fifths,
                              got.fifths, "oor", want.out_of_range, got.out_of_range);
               end
            end
         end
         // register writes; spare indexes do nothing
         if (csr_we) begin
            case (csr_index)
               CSR_HEIGHT: rows_per_column = csr_wdata;
               CSR_WIDTH:  column_count    = csr_wdata;
               default: ;
            endcase
         end
         // request side: store pixels, predict query words
         if (req_valid && req_ready) begin
            if (req_op == OP_WRITE)
               image_store[req_pixel_addr] = req_pixel_value;
            else
               pending_backgrounds.push_back(lowest_five_mean(req_bead_x, req_bead_y));
         end
      end
      mismatch_count   <= mismatches;
      backgrounds_owed <= pending_backgrounds.size();
   end

endmodule

@@ sim/window_lowest_five_background_unit_tb.sv @@
`timescale 1ns / 100ps

module window_lowest_five_background_unit_tb;
   import wlfb_pkg::*;

   localparam int RADIUS       = WINDOW_RADIUS_DEF;
   localparam int DEPTH        = PIXEL_DEPTH_DEF;
   localparam int FILL_WORDS   = 480;
   localparam int PHASE_WORDS  = 145;
   localparam int PHASES       = 6;
   localparam int DRAIN_CYCLES = 320;
   localparam int HOLD_CYCLES  = 2500;
   localparam int CYCLE_LIMIT  = 2000000;

   localparam logic [CSR_IDX_W-1:0]  CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0]  CSR_SPARE_HI = 2'd3;
   localparam logic [PIXEL_BITS-1:0] PIXEL_MAX    = '1;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_op;
   logic [ADDR_IN_W-1:0]  req_pixel_addr;
   logic [PIXEL_BITS-1:0] req_pixel_value;
   logic [COORD_W-1:0]    req_bead_x;
   logic [COORD_W-1:0]    req_bead_y;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [WHOLE_W-1:0]    rsp_background_whole;
   logic [FIFTHS_W-1:0]   rsp_background_fifths;
   logic                  rsp_out_of_range;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [REG_W-1:0]      csr_wdata;

   int mismatch_count;
   int backgrounds_owed;

   // stimulus-side view of the geometry and of which pixels hold data
   bit pixel_written [DEPTH];
   int rows_cfg = HEIGHT_RESET;
   int cols_cfg = WIDTH_RESET;

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int holds_asked   = 0;
   int holds_done    = 0;
   int cycle_count   = 0;

   int rows_plan [PHASES] = '{17, 24, 40, 4096, 4096, 20};
   int cols_plan [PHASES] = '{4096, 40, 24, 17, 4096, 33};

   always #1 clock = ~clock;

   window_lowest_five_background_unit i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_op                (req_op),
      .req_pixel_addr        (req_pixel_addr),
      .req_pixel_value       (req_pixel_value),
      .req_bead_x            (req_bead_x),
      .req_bead_y            (req_bead_y),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_background_whole  (rsp_background_whole),
      .rsp_background_fifths (rsp_background_fifths),
      .rsp_out_of_range      (rsp_out_of_range),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   wlfb_background_checker i_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_op                (req_op),
      .req_pixel_addr        (req_pixel_addr),
      .req_pixel_value       (req_pixel_value),
      .req_bead_x            (req_bead_x),
      .req_bead_y            (req_bead_y),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_background_whole  (rsp_background_whole),
      .rsp_background_fifths (rsp_background_fifths),
      .rsp_out_of_range      (rsp_out_of_range),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .mismatch_count        (mismatch_count),
      .backgrounds_owed      (backgrounds_owed)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("window_lowest_five_background_unit regression: fail");
         $finish;
      end
   end

   // result receiver: random stalls, plus long hold-offs on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_asked != holds_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // true when the query reads no pixel that was never written
   function automatic bit window_is_safe(input logic [COORD_W-1:0] bx,
                                         input logic [COORD_W-1:0] by);
      int cx, cy;
      cx = bx >> FRAC_BITS;
      cy = by >> FRAC_BITS;
      if (bx[FRAC_BITS-1:0] == '0) cx--;
      if (by[FRAC_BITS-1:0] == '0) cy--;
      if (cx < RADIUS || cy < RADIUS || cx + RADIUS >= cols_cfg ||
          cy + RADIUS >= rows_cfg || (cx + RADIUS) * rows_cfg + cy + RADIUS >= DEPTH)
         return 1'b1;
      for (int c = cx - RADIUS; c <= cx + RADIUS; c++)
         for (int r = cy - RADIUS; r <= cy + RADIUS; r++)
            if (!pixel_written[c * rows_cfg + r])
               return 1'b0;
      return 1'b1;
   endfunction

   // coordinate whose window centre is the given one; zero fraction now and then
   function automatic logic [COORD_W-1:0] coord_for_centre(input int centre);
      int frac;
      frac = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(255, 1));
      if (frac == 0)
         return COORD_W'((centre + 1) << FRAC_BITS);
      return COORD_W'((centre << FRAC_BITS) | frac);
   endfunction

   // offer one word, hold it until taken, then maybe idle
   task automatic send_word(input logic                  op,
                            input logic [ADDR_IN_W-1:0]  addr,
                            input logic [PIXEL_BITS-1:0] value,
                            input logic [COORD_W-1:0]    bx,
                            input logic [COORD_W-1:0]    by);
      req_valid       <= 1'b1;
      req_op          <= op;
      req_pixel_addr  <= addr;
      req_pixel_value <= value;
      req_bead_x      <= bx;
      req_bead_y      <= by;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_WRITE)
         pixel_written[addr] = 1'b1;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   task automatic write_pixel(input logic [ADDR_IN_W-1:0] addr,
                              input logic [PIXEL_BITS-1:0] value);
      send_word(OP_WRITE, addr, value, COORD_W'($urandom), COORD_W'($urandom));
   endtask

   task automatic query_bead(input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by);
      send_word(OP_QUERY, ADDR_IN_W'($urandom), PIXEL_BITS'($urandom), bx, by);
   endtask

   // query anywhere: wild coordinates or near the image edges
   task automatic query_stray();
      logic [COORD_W-1:0] bx, by;
      forever begin
         if ($urandom_range(1) == 0) begin
            bx = COORD_W'($urandom);
            by = COORD_W'($urandom);
         end else begin
            bx = coord_for_centre(int'($urandom_range(cols_cfg + RADIUS)));
            by = coord_for_centre(int'($urandom_range(rows_cfg + RADIUS)));
         end
         if (window_is_safe(bx, by)) break;
      end
      query_bead(bx, by);
   endtask

   // drop valid, wait for every owed word, then let the block settle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (backgrounds_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // height, a spare index, then width, with the enable held high throughout
   task automatic configure(input int rows, input int cols);
      wait_quiet();
      csr_we    <= 1'b1;
      csr_index <= CSR_HEIGHT;
      csr_wdata <= REG_W'(rows);
      @(posedge clock);
      csr_index <= ($urandom_range(1) == 0) ? CSR_SPARE_LO : CSR_SPARE_HI;
      csr_wdata <= REG_W'($urandom);
      @(posedge clock);
      csr_index <= CSR_WIDTH;
      csr_wdata <= REG_W'(cols);
      @(posedge clock);
      csr_we   <= 1'b0;
      rows_cfg = rows;
      cols_cfg = cols;
   endtask

   // mixed traffic: pixel rewrites, queries on written windows, stray queries
   task automatic random_phase(input int words);
      logic [ADDR_IN_W-1:0]  addr;
      logic [PIXEL_BITS-1:0] value;
      logic [COORD_W-1:0]    bx, by;
      int                    cx_top, cy_top, pick;
      bit                    placed;
      cx_top = (cols_cfg - 1 - RADIUS > 60) ? 60 : cols_cfg - 1 - RADIUS;
      cy_top = (rows_cfg - 1 - RADIUS > 60) ? 60 : rows_cfg - 1 - RADIUS;
      repeat (words) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            if ($urandom_range(99) < 85)
               addr = ADDR_IN_W'($urandom_range(FILL_WORDS - 1));
            else
               addr = ADDR_IN_W'($urandom);
            case ($urandom_range(9))
               0:       value = '0;
               1:       value = PIXEL_MAX;
               2, 3, 4: value = PIXEL_BITS'($urandom_range(31));
               default: value = PIXEL_BITS'($urandom);
            endcase
            write_pixel(addr, value);
         end else if (pick < 88) begin
            placed = 1'b0;
            for (int attempt = 0; attempt < 40 && !placed && cx_top >= RADIUS &&
                 cy_top >= RADIUS; attempt++) begin
               bx     = coord_for_centre(int'($urandom_range(cx_top, RADIUS)));
               by     = coord_for_centre(int'($urandom_range(cy_top, RADIUS)));
               placed = window_is_safe(bx, by);
            end
            if (placed)
               query_bead(bx, by);
            else
               query_stray();
         end else begin
            query_stray();
         end
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_op          <= OP_WRITE;
      req_pixel_addr  <= '0;
      req_pixel_value <= '0;
      req_bead_x      <= '0;
      req_bead_y      <= '0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_HEIGHT;
      csr_wdata       <= '0;
      send_idle_pct = 7;
      rsp_idle_pct  <= 64;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: extreme writes and windows off each image edge
      write_pixel('0, '0);
      write_pixel('1, PIXEL_MAX);
      write_pixel(16'h5555, 16'haaaa);
      write_pixel(16'haaaa, 16'h5555);
      query_bead('0, '0);
      query_bead('1, '1);
      query_bead(24'h00f880, 24'h006480);
      query_bead(24'h006480, 24'h00f880);
      query_bead(24'h000840, 24'h000800);
      query_bead(24'h0007ff, 24'h000880);

      // smallest image, filled bright, then one dark corner set
      configure(17, 17);
      for (int i = 0; i < FILL_WORDS; i++)
         write_pixel(ADDR_IN_W'(i), PIXEL_MAX);
      query_bead(24'h000880, 24'h000880);
      query_bead(24'h000900, 24'h000900);
      query_bead(24'h000901, 24'h000801);
      query_bead(24'h000801, 24'h000901);
      write_pixel(ADDR_IN_W'(0), PIXEL_BITS'(1));
      write_pixel(ADDR_IN_W'(144), PIXEL_BITS'(2));
      write_pixel(ADDR_IN_W'(288), PIXEL_BITS'(3));
      write_pixel(ADDR_IN_W'(16), PIXEL_BITS'(4));
      write_pixel(ADDR_IN_W'(272), PIXEL_BITS'(4));
      query_bead(24'h000880, 24'h000880);

      // random phases over several geometries and idle patterns
      for (int p = 0; p < PHASES; p++) begin
         configure(rows_plan[p], cols_plan[p]);
         if (p < 2) begin
            send_idle_pct = 7;
            rsp_idle_pct  <= 64;
         end else if (p < 4) begin
            send_idle_pct = 64;
            rsp_idle_pct  <= 7;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  <= 0;
         end
         // long receiver hold-off so the block backs up into the request side
         if (p == 1)
            holds_asked <= holds_asked + 1;
         random_phase(PHASE_WORDS);
      end

      wait_quiet();
      if (mismatch_count == 0)
         $display("window_lowest_five_background_unit regression: pass");
      else
         $display("window_lowest_five_background_unit regression: fail");
      $finish;
   end

endmodule
